/* rtl/assert_macros.svh */
// Assertion macros shared by the motion board watchdog RTL.
// Sampled on clk, disabled while rst_n is low; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define MBCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBCW_ASSERT(label, prop, msg)
`define MBCW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/mbcw_pkg.sv */
// Types and constants for the motion board command and watchdog block.
// No dependencies; imported by every module of the block.
package mbcw_pkg;

    typedef enum logic [1:0] {
        MODE_DISABLED  = 2'd0,
        MODE_ENABLED   = 2'd1,
        MODE_SAFE_STOP = 2'd2,
        MODE_FAULT     = 2'd3
    } board_mode_t;

    typedef enum logic [1:0] {
        WD_IDLE    = 2'd0,
        WD_ARMED   = 2'd1,
        WD_TRIPPED = 2'd2
    } wd_mode_t;

    typedef enum logic [1:0] {
        KIND_ACK       = 2'd0,
        KIND_FAULT     = 2'd1,
        KIND_TELEMETRY = 2'd2
    } reply_kind_t;

    typedef enum logic [2:0] {
        REQ_BAD_FRAME = 3'd0,
        REQ_ENABLE    = 3'd1,
        REQ_CONFIG    = 3'd2,
        REQ_COMMAND   = 3'd3,
        REQ_HEARTBEAT = 3'd4,
        REQ_STOP      = 3'd5,
        REQ_UNKNOWN   = 3'd6,
        REQ_WATCHDOG  = 3'd7
    } req_type_t;

    typedef enum logic [3:0] {
        OP_BAD_FRAME,
        OP_WATCHDOG,
        OP_UNKNOWN,
        OP_SIZE_FAULT,
        OP_ENABLE,
        OP_DISABLE,
        OP_CFG_BLINK_ON,
        OP_CFG_BLINK_RATE,
        OP_CFG_BAD_KEY,
        OP_MOTION,
        OP_HEARTBEAT,
        OP_STOP
    } op_t;

    localparam logic [1:0] KEY_BLINK_ON   = 2'd0;
    localparam logic [1:0] KEY_BLINK_RATE = 2'd1;

    localparam logic [1:0] CFG_WATCHDOG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DISABLED_STOP    = 2'd1;
    localparam logic [1:0] CFG_WATCHDOG_STOP    = 2'd2;

    localparam logic [31:0] WATCHDOG_TIMEOUT_RST = 32'd500;
    localparam logic [7:0]  DISABLED_STOP_RST    = 8'd1;
    localparam logic [7:0]  WATCHDOG_STOP_RST    = 8'd2;

    localparam logic [3:0] FLT_PROTOCOL        = 4'h1;
    localparam logic [3:0] FLT_DISABLED_CMD    = 4'h2;
    localparam logic [3:0] FLT_UNSUPPORTED_MSG = 4'h4;
    localparam logic [3:0] FLT_UNSUPPORTED_CFG = 4'h8;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [7:0]  seq;
        logic [31:0] cfg_value;
        logic [2:0]  flags;
        logic [31:0] stepper_one;
        logic [31:0] stepper_two;
        logic [15:0] servo;
        logic [7:0]  reason;
    } cmd_t;

    typedef struct packed {
        reply_kind_t kind;
        logic [7:0]  seq;
        logic [3:0]  faults;
        board_mode_t mode;
        wd_mode_t    wd;
        logic [7:0]  last_seq;
        logic [31:0] stepper_one;
        logic [31:0] stepper_two;
        logic [15:0] servo;
        logic [7:0]  stop_cause;
        logic        blink_on;
        logic [31:0] blink_rate;
    } res_t;

    typedef struct packed {
        board_mode_t mode;
        wd_mode_t    wd;
        logic [3:0]  faults;
    } status_t;

endpackage

/* rtl/motion_board_command_watchdog_fsm.sv */
// Motion board command and watchdog block: front classifier, back executor, result queue.
// A request is registered in the front queue, executed by the back end and its reply registered in the result queue.
// Throughput: one request per cycle while the result queue has room; a full result queue stalls the back end.
// Reset: rst_n async low; both queues empty, board disabled, watchdog idle, config defaults.
// Depends on mbcw_pkg, mbcw_front, mbcw_back, mbcw_res_fifo, assert_macros.svh.
`include "assert_macros.svh"
module motion_board_command_watchdog_fsm
    import mbcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         req_type,
    input  logic [31:0]        now_ms,
    input  logic [7:0]         sequence_req,
    input  logic               size_ok,
    input  logic               enable_flag,
    input  logic [1:0]         setting_key,
    input  logic [31:0]        config_value,
    input  logic [2:0]         update_mask,
    input  logic signed [31:0] stepper_one_value,
    input  logic signed [31:0] stepper_two_value,
    input  logic [15:0]        servo_value,
    input  logic [7:0]         stop_reason,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         reply_kind,
    output logic [7:0]         reply_sequence,
    output logic [3:0]         fault_flags,
    output logic [1:0]         board_mode,
    output logic [1:0]         watchdog_mode,
    output logic [7:0]         last_sequence,
    output logic signed [31:0] stepper_one_target,
    output logic signed [31:0] stepper_two_target,
    output logic [15:0]        servo_setpoint,
    output logic [7:0]         stop_cause,
    output logic               blink_on,
    output logic [31:0]        blink_rate,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_take;
    logic    res_full;
    logic    res_push;
    res_t    res;
    res_t    res_out;
    status_t status;

    mbcw_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .now_ms            (now_ms),
        .sequence_req      (sequence_req),
        .size_ok           (size_ok),
        .enable_flag       (enable_flag),
        .setting_key       (setting_key),
        .config_value      (config_value),
        .update_mask       (update_mask),
        .stepper_one_value (stepper_one_value),
        .stepper_two_value (stepper_two_value),
        .servo_value       (servo_value),
        .stop_reason       (stop_reason),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_take          (cmd_take)
    );

    mbcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mbcw_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign reply_kind         = res_out.kind;
    assign reply_sequence     = res_out.seq;
    assign fault_flags        = res_out.faults;
    assign board_mode         = res_out.mode;
    assign watchdog_mode      = res_out.wd;
    assign last_sequence      = res_out.last_seq;
    assign stepper_one_target = res_out.stepper_one;
    assign stepper_two_target = res_out.stepper_two;
    assign servo_setpoint     = res_out.servo;
    assign stop_cause         = res_out.stop_cause;
    assign blink_on           = res_out.blink_on;
    assign blink_rate         = res_out.blink_rate;

    `MBCW_ASSERT(a_no_push_when_full, res_push |-> !res_full, "reply pushed into full queue")
    `MBCW_ASSERT(a_trip_enters_stop, $rose(status.wd == WD_TRIPPED) |-> (status.mode == MODE_SAFE_STOP), "watchdog trip without safe stop")
    `MBCW_ASSERT_NEXT(a_faults_sticky, 1'b1, (status.faults & $past(status.faults)) == $past(status.faults), "sticky fault bit cleared")

endmodule

/* rtl/mbcw_front.sv */
// Front end: classifies each accepted request and holds it in a two-entry queue.
// Depends on mbcw_pkg.
module mbcw_front
    import mbcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic [7:0]  sequence_req,
    input  logic        size_ok,
    input  logic        enable_flag,
    input  logic [1:0]  setting_key,
    input  logic [31:0] config_value,
    input  logic [2:0]  update_mask,
    input  logic [31:0] stepper_one_value,
    input  logic [31:0] stepper_two_value,
    input  logic [15:0] servo_value,
    input  logic [7:0]  stop_reason,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    cmd_t       cmd_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push_ok;
    op_t        op;
    cmd_t       entry;

    always_comb
    begin
        case (req_type_t'(req_type))
            REQ_BAD_FRAME: op = OP_BAD_FRAME;
            REQ_WATCHDOG:  op = OP_WATCHDOG;
            REQ_UNKNOWN:   op = OP_UNKNOWN;
            REQ_ENABLE:    op = enable_flag ? OP_ENABLE : OP_DISABLE;
            REQ_CONFIG:
            begin
                case (setting_key)
                    KEY_BLINK_ON:   op = OP_CFG_BLINK_ON;
                    KEY_BLINK_RATE: op = OP_CFG_BLINK_RATE;
                    default:        op = OP_CFG_BAD_KEY;
                endcase
            end
            REQ_COMMAND:   op = OP_MOTION;
            REQ_HEARTBEAT: op = OP_HEARTBEAT;
            REQ_STOP:      op = OP_STOP;
            default:       op = OP_UNKNOWN;
        endcase
        // size check applies to enable, config, command, heartbeat and stop frames
        if (!size_ok && (req_type_t'(req_type) == REQ_ENABLE
                         || req_type_t'(req_type) == REQ_CONFIG
                         || req_type_t'(req_type) == REQ_COMMAND
                         || req_type_t'(req_type) == REQ_HEARTBEAT
                         || req_type_t'(req_type) == REQ_STOP))
        begin
            op = OP_SIZE_FAULT;
        end
    end

    always_comb
    begin
        entry.op          = op;
        entry.now_ms      = now_ms;
        entry.seq         = sequence_req;
        entry.cfg_value   = config_value;
        entry.flags       = update_mask;
        entry.stepper_one = stepper_one_value;
        entry.stepper_two = stepper_two_value;
        entry.servo       = servo_value;
        entry.reason      = stop_reason;
    end

    assign full      = (count_reg == 2'd2);
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = cmd_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push_ok, cmd_take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            cmd_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

/* rtl/mbcw_back.sv */
// Back end: board, watchdog and target state; executes one request per cycle while its reply fits in the result queue.
// Holds the configuration registers. Depends on mbcw_pkg.
module mbcw_back
    import mbcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    input  logic        res_full,
    output logic        res_push,
    output res_t        res,
    output status_t     status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] wd_timeout_reg;
    logic [7:0]  dis_code_reg;
    logic [7:0]  wd_code_reg;

    board_mode_t mode_reg,        mode_next;
    wd_mode_t    wd_reg,          wd_next;
    logic [3:0]  fault_reg,       fault_next;
    logic [7:0]  seq_reg,         seq_next;
    logic [31:0] rx_time_reg,     rx_time_next;
    logic [31:0] stepper_one_reg, stepper_one_next;
    logic [31:0] stepper_two_reg, stepper_two_next;
    logic [15:0] servo_reg,       servo_next;
    logic [7:0]  stop_reg,        stop_next;
    logic        blink_on_reg,    blink_on_next;
    logic [31:0] blink_rate_reg,  blink_rate_next;

    reply_kind_t kind;
    logic        emits;
    logic [7:0]  reply_seq;
    logic [31:0] elapsed;
    logic        do_stop;
    logic [7:0]  stop_code;
    logic [3:0]  new_faults;

    assign elapsed  = cmd.now_ms - rx_time_reg;
    assign emits    = (cmd.op != OP_WATCHDOG);
    assign cmd_take = cmd_valid && (!emits || !res_full);
    assign res_push = cmd_take && emits;

    always_comb
    begin
        mode_next        = mode_reg;
        wd_next          = wd_reg;
        fault_next       = fault_reg;
        seq_next         = seq_reg;
        rx_time_next     = rx_time_reg;
        stepper_one_next = stepper_one_reg;
        stepper_two_next = stepper_two_reg;
        servo_next       = servo_reg;
        stop_next        = stop_reg;
        blink_on_next    = blink_on_reg;
        blink_rate_next  = blink_rate_reg;
        kind             = KIND_ACK;
        reply_seq        = cmd.seq;
        do_stop          = 1'b0;
        stop_code        = cmd.reason;
        new_faults       = 4'h0;

        if (cmd.op != OP_WATCHDOG && cmd.op != OP_BAD_FRAME)
        begin
            seq_next     = cmd.seq;
            rx_time_next = cmd.now_ms;
        end

        case (cmd.op)
            OP_WATCHDOG:
            begin
                if (mode_reg == MODE_ENABLED && elapsed > wd_timeout_reg)
                begin
                    wd_next   = WD_TRIPPED;
                    do_stop   = 1'b1;
                    stop_code = wd_code_reg;
                    mode_next = MODE_SAFE_STOP;
                end
            end
            OP_BAD_FRAME:
            begin
                new_faults = FLT_PROTOCOL;
                reply_seq  = 8'd0;
            end
            OP_UNKNOWN:     new_faults = FLT_UNSUPPORTED_MSG;
            OP_SIZE_FAULT:  new_faults = FLT_PROTOCOL;
            OP_CFG_BAD_KEY: new_faults = FLT_UNSUPPORTED_CFG;
            OP_ENABLE:
            begin
                mode_next = MODE_ENABLED;
                wd_next   = WD_ARMED;
                stop_next = 8'd0;
            end
            OP_DISABLE:
            begin
                do_stop   = 1'b1;
                stop_code = dis_code_reg;
                mode_next = MODE_DISABLED;
            end
            OP_CFG_BLINK_ON:   blink_on_next   = (cmd.cfg_value != 32'd0);
            OP_CFG_BLINK_RATE: blink_rate_next = cmd.cfg_value;
            OP_MOTION:
            begin
                if (mode_reg != MODE_ENABLED)
                begin
                    new_faults = FLT_DISABLED_CMD;
                end
                else
                begin
                    wd_next = WD_ARMED;
                    if (cmd.flags[0]) stepper_one_next = cmd.stepper_one;
                    if (cmd.flags[1]) stepper_two_next = cmd.stepper_two;
                    if (cmd.flags[2]) servo_next       = cmd.servo;
                end
            end
            OP_HEARTBEAT:
            begin
                if (mode_reg == MODE_ENABLED) wd_next = WD_ARMED;
                kind = KIND_TELEMETRY;
            end
            OP_STOP:
            begin
                do_stop   = 1'b1;
                mode_next = MODE_SAFE_STOP;
            end
            default:
            begin
                new_faults = FLT_UNSUPPORTED_MSG;
            end
        endcase

        if (do_stop)
        begin
            stepper_one_next = 32'd0;
            stepper_two_next = 32'd0;
            servo_next       = 16'd0;
            stop_next        = stop_code;
        end

        if (new_faults != 4'h0)
        begin
            mode_next  = MODE_FAULT;
            fault_next = fault_reg | new_faults;
            kind       = KIND_FAULT;
        end
    end

    always_comb
    begin
        res.kind        = kind;
        res.seq         = reply_seq;
        res.faults      = fault_next;
        res.mode        = mode_next;
        res.wd          = wd_next;
        res.last_seq    = seq_next;
        res.stepper_one = stepper_one_next;
        res.stepper_two = stepper_two_next;
        res.servo       = servo_next;
        res.stop_cause  = stop_next;
        res.blink_on    = blink_on_next;
        res.blink_rate  = blink_rate_next;
    end

    assign status.mode   = mode_reg;
    assign status.wd     = wd_reg;
    assign status.faults = fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_timeout_reg <= WATCHDOG_TIMEOUT_RST;
            dis_code_reg   <= DISABLED_STOP_RST;
            wd_code_reg    <= WATCHDOG_STOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WATCHDOG_TIMEOUT: wd_timeout_reg <= cfg_wdata;
                CFG_DISABLED_STOP:    dis_code_reg   <= cfg_wdata[7:0];
                CFG_WATCHDOG_STOP:    wd_code_reg    <= cfg_wdata[7:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DISABLED;
            wd_reg          <= WD_IDLE;
            fault_reg       <= 4'h0;
            seq_reg         <= 8'd0;
            rx_time_reg     <= 32'd0;
            stepper_one_reg <= 32'd0;
            stepper_two_reg <= 32'd0;
            servo_reg       <= 16'd0;
            stop_reg        <= 8'd0;
            blink_on_reg    <= 1'b0;
            blink_rate_reg  <= 32'd0;
        end
        else if (cmd_take)
        begin
            mode_reg        <= mode_next;
            wd_reg          <= wd_next;
            fault_reg       <= fault_next;
            seq_reg         <= seq_next;
            rx_time_reg     <= rx_time_next;
            stepper_one_reg <= stepper_one_next;
            stepper_two_reg <= stepper_two_next;
            servo_reg       <= servo_next;
            stop_reg        <= stop_next;
            blink_on_reg    <= blink_on_next;
            blink_rate_reg  <= blink_rate_next;
        end
    end

endmodule

/* rtl/mbcw_res_fifo.sv */
// Two-entry result queue between the back end and the reply ports.
// Depends on mbcw_pkg.
module mbcw_res_fifo
    import mbcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_in,
    output logic res_full,
    input  logic pop,
    output logic empty,
    output res_t res_out
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop_ok;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_ok   = pop && !empty;
    assign res_out  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = res_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        case ({res_push, pop_ok})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule
